// ===== design/ebpf_alu32_execute_assert.svh =====
// Assertion macros used by the checker of the ALU32 execute block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef EBPF_ALU32_EXECUTE_ASSERT_SVH
`define EBPF_ALU32_EXECUTE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ealu_pkg.sv =====
// Shared constants and types for the ALU32 execute block.
// Used by the top level, the divider and the checker; depends on nothing.
package ealu_pkg;

    localparam int NUM_REGS   = 11;
    localparam int REG_IDX_W  = 4;
    localparam int WORD_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int SHAMT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int OPCODE_W   = 8;
    localparam int OP_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] NUM_REGS_IDX = REG_IDX_W'(NUM_REGS);
    localparam logic [REG_IDX_W-1:0] CTX_REG      = 4'd1;
    localparam logic [REG_IDX_W-1:0] FRAME_REG    = 4'd10;

    localparam logic [2:0] CLASS_ALU32 = 3'b100;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD  = 4'h0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'h1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'h2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'h3;
    localparam logic [OP_W-1:0] OP_OR   = 4'h4;
    localparam logic [OP_W-1:0] OP_AND  = 4'h5;
    localparam logic [OP_W-1:0] OP_LSH  = 4'h6;
    localparam logic [OP_W-1:0] OP_RSH  = 4'h7;
    localparam logic [OP_W-1:0] OP_NEG  = 4'h8;
    localparam logic [OP_W-1:0] OP_MOD  = 4'h9;
    localparam logic [OP_W-1:0] OP_XOR  = 4'hA;
    localparam logic [OP_W-1:0] OP_MOV  = 4'hB;
    localparam logic [OP_W-1:0] OP_ARSH = 4'hC;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== design/ealu_divider.sv =====
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on ealu_pkg for widths and the request and response structs.
module ealu_divider
    import ealu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] quo_next;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[WORD_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (trial[WORD_W])
        begin
            rem_next = shifted[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/ebpf_alu32_execute.sv =====
// Each item passes through the read, execute and done states, with the divider state between
// execute and done for div and mod; first_of_program adds the context and frame writes first.
// The block takes no new item until it has finished with the last; input is not ready meanwhile.
// The register file is a small memory with one write and two registered reads per cycle.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the configuration
// registers and the per-register valid bits, so every register reads as zero.
module ebpf_alu32_execute
    import ealu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode [7:0], dst_reg [11:8], src_reg [15:12], immediate [47:16]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // first_of_program [0]
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // written_reg [3:0], written_value [67:4], zero pad [71:68]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CTX   = 3'd1;
    localparam logic [2:0] S_FRAME = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic [OPCODE_W-1:0]  opcode_reg;
    logic [REG_IDX_W-1:0] dst_idx_reg;
    logic [REG_IDX_W-1:0] src_idx_reg;
    logic [WORD_W-1:0]    imm_reg;

    // Only the low word of a register is ever observed, so only it is stored.
    logic [WORD_W-1:0]    ctx_reg;
    logic [WORD_W-1:0]    stack_reg;
    logic [WORD_W-1:0]    mem [NUM_REGS];
    logic [NUM_REGS-1:0]  vld_reg;
    logic [WORD_W-1:0]    rd_a_reg;
    logic [WORD_W-1:0]    rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;

    logic [STATUS_W-1:0]  res_status_reg;
    logic [WORD_W-1:0]    res_value_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [REG_IDX_W-1:0] out_dst_reg;
    logic [WORD_W-1:0]    out_value_reg;

    logic [OP_W-1:0]      op;
    logic                 use_src;
    logic                 bad;
    logic                 is_divmod;
    logic [WORD_W-1:0]    opnd_a;
    logic [WORD_W-1:0]    opnd_b;
    logic [SHAMT_W-1:0]   shamt;
    logic [WORD_W-1:0]    alu_value;
    logic                 accept;
    logic                 out_free;
    logic                 mem_we;
    logic [REG_IDX_W-1:0] mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [REG_IDX_W-1:0] rd_a_addr;
    logic [REG_IDX_W-1:0] rd_b_addr;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // Instruction decode on the captured item.
    assign op        = opcode_reg[OPCODE_W-1:OPCODE_W-OP_W];
    assign use_src   = opcode_reg[3];
    assign is_divmod = (op == OP_DIV) || (op == OP_MOD);
    assign bad       = (opcode_reg[2:0] != CLASS_ALU32) || (op > OP_ARSH)
                     || ((op == OP_NEG) && use_src)
                     || (dst_idx_reg >= NUM_REGS_IDX)
                     || (use_src && (op != OP_NEG) && (src_idx_reg >= NUM_REGS_IDX));

    assign opnd_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign opnd_b = use_src ? (rd_b_vld_reg ? rd_b_reg : '0) : imm_reg;
    assign shamt  = opnd_b[SHAMT_W-1:0];

    always_comb
    begin
        case (op)
            OP_ADD:  alu_value = opnd_a + opnd_b;
            OP_SUB:  alu_value = opnd_a - opnd_b;
            OP_MUL:  alu_value = opnd_a * opnd_b;
            OP_OR:   alu_value = opnd_a | opnd_b;
            OP_AND:  alu_value = opnd_a & opnd_b;
            OP_LSH:  alu_value = opnd_a << shamt;
            OP_RSH:  alu_value = opnd_a >> shamt;
            OP_NEG:  alu_value = '0 - opnd_a;
            OP_XOR:  alu_value = opnd_a ^ opnd_b;
            OP_MOV:  alu_value = opnd_b;
            OP_ARSH: alu_value = WORD_W'($signed(opnd_a) >>> shamt);
            default: alu_value = '0;
        endcase
    end

    assign div_req.start    = (state_reg == S_EXEC) && !bad && is_divmod && (opnd_b != '0);
    assign div_req.dividend = opnd_a;
    assign div_req.divisor  = opnd_b;

    ealu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // An out-of-range index only occurs on an item that is rejected or that does not use it, so clamp it.
    assign rd_a_addr = (dst_idx_reg < NUM_REGS_IDX) ? dst_idx_reg : '0;
    assign rd_b_addr = (src_idx_reg < NUM_REGS_IDX) ? src_idx_reg : '0;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_idx_reg;
        mem_wdata = res_value_reg;
        case (state_reg)
            S_CTX:
            begin
                mem_we    = 1'b1;
                mem_waddr = CTX_REG;
                mem_wdata = ctx_reg;
            end
            S_FRAME:
            begin
                mem_we    = 1'b1;
                mem_waddr = FRAME_REG;
                mem_wdata = stack_reg;
            end
            S_DONE:
            begin
                mem_we = out_free && (res_status_reg == ST_OK);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_a_reg     <= mem[rd_a_addr];
            rd_b_reg     <= mem[rd_b_addr];
            rd_a_vld_reg <= vld_reg[rd_a_addr];
            rd_b_vld_reg <= vld_reg[rd_b_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_axis_tuser[0] ? S_CTX : S_READ;
                end
            end
            S_CTX:   state_next = S_FRAME;
            S_FRAME: state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = div_req.start ? S_DIV : S_DONE;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            ctx_reg       <= '0;
            stack_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CONTEXT: ctx_reg   <= cfg_data[WORD_W-1:0];
                    CFG_STACK:   stack_reg <= cfg_data[WORD_W-1:0];
                    default:     ctx_reg   <= ctx_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg  <= s_axis_tdata[7:0];
            dst_idx_reg <= s_axis_tdata[11:8];
            src_idx_reg <= s_axis_tdata[15:12];
            imm_reg     <= s_axis_tdata[47:16];
        end
        if (state_reg == S_EXEC)
        begin
            if (bad)
            begin
                res_status_reg <= ST_BAD;
                res_value_reg  <= '0;
            end
            else if (is_divmod && (opnd_b == '0))
            begin
                res_status_reg <= ST_DIVZERO;
                res_value_reg  <= '0;
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_value_reg  <= alu_value;
            end
        end
        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            res_value_reg <= (op == OP_MOD) ? div_rsp.remainder : div_rsp.quotient;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_dst_reg    <= (res_status_reg == ST_OK) ? dst_idx_reg : '0;
            out_value_reg  <= res_value_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, {(VALUE_W - WORD_W){1'b0}},
                            out_value_reg, out_dst_reg};

endmodule

// ===== design/ealu_checker.sv =====
// Port-level checks for the ALU32 execute block, bound to its top level.
// Depends on ealu_pkg and the assertion macros in ebpf_alu32_execute_assert.svh.
`include "ebpf_alu32_execute_assert.svh"

module ealu_checker
    import ealu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]    m_axis_tuser,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // A stalled result item keeps its contents.
    `EALU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result item changed while stalled")

    // The block works on one item at a time.
    `EALU_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an item was accepted")

    `EALU_ASSERT_NOW(a_status_code, m_axis_tvalid, (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_DIVZERO) || (m_axis_tuser == ST_BAD), "undefined status code")

    // A failed instruction reports neither a register nor a value.
    `EALU_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "error result carries data")

    `EALU_ASSERT_NOW(a_dst_range, m_axis_tvalid && (m_axis_tuser == ST_OK), m_axis_tdata[REG_IDX_W-1:0] < NUM_REGS_IDX, "written register index out of range")

endmodule

bind ebpf_alu32_execute ealu_checker u_ealu_checker (.*);
